// ===== rtl/kdsp_pkg.sv =====
// shared types, codes and helpers for the kd split plane selector
package kdsp_pkg;

  localparam int MAX_INTERVALS_DEF = 1024;
  localparam int AXIS_COUNT        = 3;
  localparam int QUEUE_DEPTH       = 4;

  localparam int IC_W        = 11;
  localparam int AX_W        = 2;
  localparam int COORD_W     = 32;
  localparam int COST_OUT_W  = 12;
  localparam int COST_FLOOR  = -2048;
  localparam int OUT_DATA_W  = 96;

  // register indexes of the configuration port
  localparam logic REG_INTERVAL_COUNT = 1'b0;
  localparam logic REG_START_AXIS     = 1'b1;

  // endpoint classes handed from front to back
  localparam logic [1:0] OP_FIRST = 2'd0;
  localparam logic [1:0] OP_LOW   = 2'd1;
  localparam logic [1:0] OP_HIGH  = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] coord;
    logic [1:0]         op;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [IC_W-1:0] interval_count;
    logic [AX_W-1:0] start_axis;
  } cfg_t;

  // small value reduced modulo the axis count
  function automatic logic [AX_W-1:0] axis_mod(input logic [2:0] v);
    logic [2:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (r >= 3'(AXIS_COUNT)) begin
        r = r - 3'(AXIS_COUNT);
      end
    end
    return r[AX_W-1:0];
  endfunction

endpackage

// ===== rtl/kdsp_front.sv =====
// front end: accepts endpoints and tags each as list start, low or high end
module kdsp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  logic                  q_full,
  output logic                  push,
  output kdsp_pkg::item_t       push_item
);

  logic first_of_list;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push_item.coord = s_axis_tdata;
    push_item.last  = s_axis_tlast;
    if (first_of_list) begin
      push_item.op = kdsp_pkg::OP_FIRST;
    end else if (s_axis_tuser) begin
      push_item.op = kdsp_pkg::OP_HIGH;
    end else begin
      push_item.op = kdsp_pkg::OP_LOW;
    end
  end

  // a new list begins after reset and after every list end
  always_ff @(posedge clk) begin
    if (rst) begin
      first_of_list <= 1'b1;
    end else if (push) begin
      first_of_list <= s_axis_tlast;
    end
  end

endmodule

// ===== rtl/kdsp_queue.sv =====
// short fifo of classified endpoints between front and back
module kdsp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kdsp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output kdsp_pkg::item_t head_item
);

  localparam int DEPTH = kdsp_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  kdsp_pkg::item_t mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [NW-1:0]   count;

  assign full       = (count == NW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/kdsp_back.sv =====
// back end: sweep cost update, per-node best tracking and output register
module kdsp_back #(
  parameter int MAX_INTERVALS = kdsp_pkg::MAX_INTERVALS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  kdsp_pkg::cfg_t                     cfg,
  input  logic                               head_valid,
  input  kdsp_pkg::item_t                    head_item,
  output logic                               pop,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [kdsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int CNTW = $clog2(MAX_INTERVALS + 1);
  localparam int CW   = CNTW + 3;
  localparam int EW   = (CW > 13) ? CW : 13;
  localparam logic signed [EW-1:0] FLOOR = EW'(kdsp_pkg::COST_FLOOR);

  function automatic logic [kdsp_pkg::COST_OUT_W-1:0] clamp_cost(
    input logic signed [CW-1:0] c);
    logic signed [EW-1:0] e;
    e = EW'(c);
    if (e < FLOOR) begin
      e = FLOOR;
    end
    return e[kdsp_pkg::COST_OUT_W-1:0];
  endfunction

  // sweep state
  logic [CNTW-1:0]        below_count, below_count_next;
  logic [CNTW-1:0]        above_count, above_count_next;
  logic signed [CW-1:0]   sweep_cost, sweep_cost_next;
  logic [31:0]            sweep_value, sweep_value_next;
  logic                   sweep_optimal, sweep_optimal_next;
  logic                   sweep_stopped, sweep_stopped_next;
  // node state
  logic [1:0]             axes_swept, axes_swept_next;
  logic [1:0]             node_best_axis, node_best_axis_next;
  logic [31:0]            node_best_value, node_best_value_next;
  logic signed [CW-1:0]   node_best_cost, node_best_cost_next;
  logic                   node_finished, node_finished_next;

  logic [CNTW-1:0]        n;
  logic [CNTW+2:0]        five_n;
  logic signed [CW-1:0]   n_s, bias, best_base, min_cost;
  logic [CNTW-1:0]        b1;
  logic signed [CW-1:0]   b1_s, a_s, unbal, unbal_abs, hcost;
  logic [1:0]             axes_eff;
  logic [1:0]             first_ax, axis;
  logic [kdsp_pkg::OUT_DATA_W-1:0] out_data;
  logic                   out_free;

  always_comb begin
    if (cfg.interval_count < 11'd2) begin
      n = CNTW'(2);
    end else if (32'(cfg.interval_count) > 32'(MAX_INTERVALS)) begin
      n = CNTW'(MAX_INTERVALS);
    end else begin
      n = CNTW'(cfg.interval_count);
    end
  end

  assign five_n    = {n, 2'b00} + (CNTW+3)'(n);
  assign n_s       = signed'(CW'(n));
  assign bias      = signed'(CW'(five_n >> 2));
  assign best_base = bias - (n_s <<< 1);
  assign min_cost  = best_base + signed'(CW'(n[0]));

  // cost of a high endpoint against the current counts
  assign b1        = (below_count < n) ? below_count + 1'b1 : below_count;
  assign b1_s      = signed'(CW'(b1));
  assign a_s       = signed'(CW'(above_count));
  assign unbal     = b1_s - a_s;
  assign unbal_abs = unbal[CW-1] ? -unbal : unbal;
  assign hcost     = bias - ((b1_s + a_s) <<< 1) + unbal_abs;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign pop      = head_valid && (!head_item.last || out_free);

  assign axes_eff = node_finished ? 2'd0 : axes_swept;
  assign first_ax = kdsp_pkg::axis_mod({1'b0, cfg.start_axis});
  assign axis     = kdsp_pkg::axis_mod(3'(first_ax) + 3'(axes_eff));

  always_comb begin
    below_count_next     = below_count;
    above_count_next     = above_count;
    sweep_cost_next      = sweep_cost;
    sweep_value_next     = sweep_value;
    sweep_optimal_next   = sweep_optimal;
    sweep_stopped_next   = sweep_stopped;
    axes_swept_next      = axes_swept;
    node_best_axis_next  = node_best_axis;
    node_best_value_next = node_best_value;
    node_best_cost_next  = node_best_cost;
    node_finished_next   = node_finished;

    case (head_item.op)
      kdsp_pkg::OP_FIRST: begin
        below_count_next   = '0;
        above_count_next   = n - 1'b1;
        sweep_cost_next    = '0;
        sweep_value_next   = '0;
        sweep_optimal_next = 1'b0;
        sweep_stopped_next = 1'b0;
      end
      kdsp_pkg::OP_HIGH: begin
        if (!sweep_stopped) begin
          below_count_next = b1;
          if (hcost < sweep_cost) begin
            sweep_cost_next  = hcost;
            sweep_value_next = head_item.coord;
            if (hcost == min_cost) begin
              sweep_optimal_next = 1'b1;
              sweep_stopped_next = 1'b1;
            end
          end else if (sweep_cost <= best_base + unbal) begin
            sweep_stopped_next = 1'b1;
          end
          if (b1 >= n) begin
            sweep_stopped_next = 1'b1;
          end
        end
      end
      kdsp_pkg::OP_LOW: begin
        if (!sweep_stopped && above_count != '0) begin
          above_count_next = above_count - 1'b1;
        end
      end
      default: begin
      end
    endcase

    // a finished node is cleared when the next endpoint is taken
    if (node_finished) begin
      axes_swept_next    = 2'd0;
      node_finished_next = 1'b0;
    end

    if (head_item.last) begin
      if (axes_eff == 2'd0 || sweep_cost_next < node_best_cost) begin
        node_best_axis_next  = axis;
        node_best_value_next = sweep_value_next;
        node_best_cost_next  = sweep_cost_next;
      end
      axes_swept_next = (axes_eff < 2'(kdsp_pkg::AXIS_COUNT)) ? axes_eff + 1'b1 : axes_eff;
      node_finished_next = sweep_optimal_next ||
                           (axes_swept_next >= 2'(kdsp_pkg::AXIS_COUNT));
    end
  end

  // low to high: axis_index, axis_cost, axis_split_value, axis_optimal,
  // best_axis, best_split_value, best_cost, split_found, zero fill
  assign out_data = {2'b00,
                     node_best_cost_next[CW-1],
                     clamp_cost(node_best_cost_next),
                     node_best_value_next,
                     node_best_axis_next,
                     sweep_optimal_next,
                     sweep_value_next,
                     clamp_cost(sweep_cost_next),
                     axis};

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_stopped <= 1'b0;
      sweep_optimal <= 1'b0;
      axes_swept    <= 2'd0;
      node_finished <= 1'b0;
    end else if (pop) begin
      sweep_stopped <= sweep_stopped_next;
      sweep_optimal <= sweep_optimal_next;
      axes_swept    <= axes_swept_next;
      node_finished <= node_finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      below_count     <= below_count_next;
      above_count     <= above_count_next;
      sweep_cost      <= sweep_cost_next;
      sweep_value     <= sweep_value_next;
      node_best_axis  <= node_best_axis_next;
      node_best_value <= node_best_value_next;
      node_best_cost  <= node_best_cost_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop && head_item.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      m_axis_tdata <= out_data;
      m_axis_tlast <= node_finished_next;
    end
  end

endmodule

// ===== rtl/kd_split_plane_selector_core.sv =====
// top level of the kd split plane selector
// Sweeps the sorted endpoint lists of a kd-tree node axis by axis and reports,
// at every list end, that axis's best split and the best split over the node
// so far. One endpoint is accepted every clock cycle, sustained, for as long
// as results are taken; the cost update and compare are combinational,
// registered as an endpoint is popped. A list end goes through the queue,
// then the output register; the four-entry queue between the input stage
// and the sweep unit absorbs short output stalls. Results stay in the
// output register until taken; tlast marks the result that finishes a node.
module kd_split_plane_selector_core #(
  parameter int MAX_INTERVALS = kdsp_pkg::MAX_INTERVALS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata,
  // endpoint stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // coordinate
  input  logic        s_axis_tuser,    // is_high_end
  input  logic        s_axis_tlast,    // last_of_axis
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // axis_index, axis_cost, axis_split_value, axis_optimal, best_axis,
  // best_split_value, best_cost, split_found, zero fill
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tlast     // node_done
);

  kdsp_pkg::cfg_t  cfg;
  logic            q_full;
  logic            push;
  kdsp_pkg::item_t push_item;
  logic            pop;
  logic            head_valid;
  kdsp_pkg::item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_count <= 11'd2;
      cfg.start_axis     <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        kdsp_pkg::REG_INTERVAL_COUNT: cfg.interval_count <= cfg_wdata;
        kdsp_pkg::REG_START_AXIS:     cfg.start_axis     <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  kdsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  kdsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  kdsp_back #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/kdsp_checker.sv =====
// port-level assertions for the kd split plane selector, bound to the top
module kdsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                         && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // an optimal axis always closes the node
  a_optimal_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[46] |-> m_axis_tlast)
    else $error("optimal axis without node done");

  // no useful cost means no split coordinate
  a_zero_cost_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[13:2] == 12'd0) |-> (m_axis_tdata[45:14] == 32'd0))
    else $error("split value set on an axis without gain");

  // node best never worse than this axis, and split_found follows its sign
  a_best_vs_axis: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[92:81]) <= $signed(m_axis_tdata[13:2]))
                      && (m_axis_tdata[93] == m_axis_tdata[92]))
    else $error("node best inconsistent with axis result");

endmodule

bind kd_split_plane_selector_core kdsp_checker u_kdsp_checker (.*);
